FILE: design/ble_midi_packet_builder_macros.svh
// Assertion macros for the BLE-MIDI packet builder checker.
`ifndef BLE_MIDI_PACKET_BUILDER_MACROS_SVH
`define BLE_MIDI_PACKET_BUILDER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define BMPB_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define BMPB_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: design/bmpb_pkg.sv
// Package: shared types and constants of the BLE-MIDI packet builder.
`timescale 1ns / 1ps
package bmpb_pkg;

  localparam int TIME_W = 13;
  localparam int BYTE_W = 8;
  localparam int KIND_W = 2;
  localparam int FIFO_DEPTH = 2;

  localparam logic [BYTE_W-1:0] MARK_BIT = 8'h80;

  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_EMIT = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_REJECTED = 2'd1,
    KIND_BYTE     = 2'd2,
    KIND_EMPTY    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CMD_ACCEPTED = 2'd0,
    CMD_REJECTED = 2'd1,
    CMD_EMPTY    = 2'd2,
    CMD_EMIT     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_HEADER,
    B_MSG,
    B_STATUS,
    B_DATA1,
    B_DATA2
  } back_state_t;

  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [BYTE_W-1:0] status;
    logic [BYTE_W-1:0] d1;
    logic [BYTE_W-1:0] d2;
  } msg_entry_t;

  typedef struct packed {
    logic       en;
    msg_entry_t data;
  } wr_req_t;

  typedef struct packed {
    logic done;
  } back_status_t;

endpackage

FILE: design/bmpb_in_if.sv
// Interface: input item channel (action and one MIDI message).
`timescale 1ns / 1ps
interface bmpb_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [12:0] timestamp_ms;
  logic [7:0]  status_byte;
  logic [7:0]  data_first;
  logic [7:0]  data_second;

  modport source (output valid, action, timestamp_ms, status_byte, data_first, data_second,
                  input ready);
  modport sink (input valid, action, timestamp_ms, status_byte, data_first, data_second,
                output ready);
endinterface

FILE: design/bmpb_out_if.sv
// Interface: result item channel (kind, packet byte, last flag).
`timescale 1ns / 1ps
interface bmpb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] packet_byte;
  logic       last_byte;

  modport source (output valid, result_kind, packet_byte, last_byte, input ready);
  modport sink (input valid, result_kind, packet_byte, last_byte, output ready);
endinterface

FILE: design/bmpb_front.sv
// Front end: accepts items, checks queue fill, writes messages, issues commands.
`timescale 1ns / 1ps
module bmpb_front #(
  parameter int QUEUE_DEPTH = 16,
  localparam int IDX_W = $clog2(QUEUE_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  bmpb_in_if.sink               msg_in,
  input  logic [IDX_W-1:0]      read_index,
  input  bmpb_pkg::back_status_t back_stat,
  input  logic                  fifo_full,
  output logic                  push,
  output bmpb_pkg::cmd_t        push_cmd,
  output bmpb_pkg::wr_req_t     wr,
  output logic [IDX_W-1:0]      wr_addr
);

  logic [IDX_W-1:0] write_index;
  logic [IDX_W-1:0] write_index_next;
  logic [IDX_W-1:0] write_wrap;
  logic             emit_busy;
  logic             accept;
  logic             q_full;
  logic             q_empty;

  assign write_wrap = (write_index == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : write_index + 1'b1;
  assign q_full  = (write_wrap == read_index);
  assign q_empty = (write_index == read_index);

  // Hold new items while a packet drains (the read index is moving) or while the command queue is full.
  assign msg_in.ready = !emit_busy && !fifo_full;
  assign accept = msg_in.valid && msg_in.ready;

  assign wr_addr = write_index;

  always_comb begin
    push = accept;
    push_cmd = bmpb_pkg::CMD_ACCEPTED;
    wr.en = 1'b0;
    wr.data.stamp = msg_in.timestamp_ms;
    wr.data.status = msg_in.status_byte;
    wr.data.d1 = msg_in.data_first;
    wr.data.d2 = msg_in.data_second;
    write_index_next = write_index;
    if (accept) begin
      if (msg_in.action == bmpb_pkg::ACT_ENQUEUE) begin
        if (q_full) begin
          push_cmd = bmpb_pkg::CMD_REJECTED;
        end else begin
          push_cmd = bmpb_pkg::CMD_ACCEPTED;
          wr.en = 1'b1;
          write_index_next = write_wrap;
        end
      end else begin
        push_cmd = q_empty ? bmpb_pkg::CMD_EMPTY : bmpb_pkg::CMD_EMIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      emit_busy <= 1'b0;
    end else begin
      write_index <= write_index_next;
      if (accept && msg_in.action == bmpb_pkg::ACT_EMIT && !q_empty) begin
        emit_busy <= 1'b1;
      end else if (back_stat.done) begin
        emit_busy <= 1'b0;
      end
    end
  end

endmodule

FILE: design/bmpb_cmd_fifo.sv
// Two-entry command queue between the front end and the packet back end.
`timescale 1ns / 1ps
module bmpb_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bmpb_pkg::cmd_t push_cmd,
  input  logic           pop,
  output bmpb_pkg::cmd_t pop_cmd,
  output logic           full,
  output logic           empty
);

  localparam int PTR_W = $clog2(bmpb_pkg::FIFO_DEPTH);

  bmpb_pkg::cmd_t   entries [bmpb_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;

  assign full = (fill == (PTR_W + 1)'(bmpb_pkg::FIFO_DEPTH));
  assign empty = (fill == '0);
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: design/bmpb_back.sv
// Back end: message memory, packet sequencer and output register.
`timescale 1ns / 1ps
module bmpb_back #(
  parameter int QUEUE_DEPTH = 16,
  parameter int PACKET_BYTES = 20,
  localparam int IDX_W = $clog2(QUEUE_DEPTH),
  localparam int CNT_W = $clog2(PACKET_BYTES + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  bmpb_pkg::wr_req_t      wr,
  input  logic [IDX_W-1:0]       wr_addr,
  input  logic                   cmd_avail,
  input  bmpb_pkg::cmd_t         cmd,
  output logic                   pop,
  output logic [IDX_W-1:0]       read_index,
  output bmpb_pkg::back_status_t back_stat,
  bmpb_out_if.source             res_out
);

  localparam int FILL_LIMIT = PACKET_BYTES - 4;

  bmpb_pkg::msg_entry_t mem [QUEUE_DEPTH];
  bmpb_pkg::msg_entry_t rd_data;

  bmpb_pkg::back_state_t state;
  bmpb_pkg::back_state_t state_next;

  logic [IDX_W-1:0] read_index_next;
  logic [IDX_W-1:0] read_wrap;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_inc;

  logic [bmpb_pkg::BYTE_W-1:0] prev_status;
  logic [bmpb_pkg::TIME_W-1:0] prev_time;
  logic                        prev_valid;

  logic                        out_valid;
  bmpb_pkg::kind_t             out_kind;
  logic [bmpb_pkg::BYTE_W-1:0] out_byte;
  logic                        out_last;

  logic                        can_load;
  logic                        match;
  logic                        pkt_end;
  logic                        load;
  bmpb_pkg::kind_t             load_kind;
  logic [bmpb_pkg::BYTE_W-1:0] load_byte;
  logic                        load_last;
  logic                        adv;
  logic                        clr_prev;

  assign can_load = !out_valid || res_out.ready;
  assign match = prev_valid && (prev_status == rd_data.status) && (prev_time == rd_data.stamp);
  assign read_wrap = (read_index == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : read_index + 1'b1;
  assign count_inc = count + 1'b1;
  // Close the packet when the queue runs dry or no room is left for a full message.
  assign pkt_end = (read_wrap == wr_addr) || (count_inc > CNT_W'(FILL_LIMIT));
  assign read_index_next = adv ? read_wrap : read_index;

  always_comb begin
    state_next = state;
    case (state)
      bmpb_pkg::B_IDLE: begin
        if (cmd_avail && can_load && cmd == bmpb_pkg::CMD_EMIT) begin
          state_next = bmpb_pkg::B_HEADER;
        end
      end
      bmpb_pkg::B_HEADER: begin
        if (can_load) state_next = bmpb_pkg::B_MSG;
      end
      bmpb_pkg::B_MSG: begin
        if (can_load) state_next = match ? bmpb_pkg::B_DATA2 : bmpb_pkg::B_STATUS;
      end
      bmpb_pkg::B_STATUS: begin
        if (can_load) state_next = bmpb_pkg::B_DATA1;
      end
      bmpb_pkg::B_DATA1: begin
        if (can_load) state_next = bmpb_pkg::B_DATA2;
      end
      bmpb_pkg::B_DATA2: begin
        if (can_load) state_next = pkt_end ? bmpb_pkg::B_IDLE : bmpb_pkg::B_MSG;
      end
      default: state_next = bmpb_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    load = 1'b0;
    load_kind = bmpb_pkg::KIND_BYTE;
    load_byte = '0;
    load_last = 1'b0;
    pop = 1'b0;
    adv = 1'b0;
    clr_prev = 1'b0;
    back_stat.done = 1'b0;
    case (state)
      bmpb_pkg::B_IDLE: begin
        if (cmd_avail && can_load) begin
          pop = 1'b1;
          load_last = 1'b1;
          case (cmd)
            bmpb_pkg::CMD_ACCEPTED: begin
              load = 1'b1;
              load_kind = bmpb_pkg::KIND_ACCEPTED;
            end
            bmpb_pkg::CMD_REJECTED: begin
              load = 1'b1;
              load_kind = bmpb_pkg::KIND_REJECTED;
            end
            bmpb_pkg::CMD_EMPTY: begin
              load = 1'b1;
              load_kind = bmpb_pkg::KIND_EMPTY;
            end
            default: clr_prev = 1'b1;
          endcase
        end
      end
      bmpb_pkg::B_HEADER: begin
        load = can_load;
        load_byte = bmpb_pkg::MARK_BIT | {2'b00, rd_data.stamp[12:7]};
      end
      bmpb_pkg::B_MSG: begin
        load = can_load;
        // Running status: same status and time as the last message skips two bytes.
        load_byte = match ? rd_data.d1 : (bmpb_pkg::MARK_BIT | {1'b0, rd_data.stamp[6:0]});
      end
      bmpb_pkg::B_STATUS: begin
        load = can_load;
        load_byte = rd_data.status;
      end
      bmpb_pkg::B_DATA1: begin
        load = can_load;
        load_byte = rd_data.d1;
      end
      bmpb_pkg::B_DATA2: begin
        load = can_load;
        load_byte = rd_data.d2;
        load_last = pkt_end;
        adv = can_load;
        back_stat.done = can_load && pkt_end;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
    rd_data <= mem[read_index_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bmpb_pkg::B_IDLE;
      read_index <= '0;
      count <= '0;
      prev_status <= '0;
      prev_time <= '0;
      prev_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      read_index <= read_index_next;
      if (load && state == bmpb_pkg::B_HEADER) begin
        count <= CNT_W'(1);
      end else if (load && state != bmpb_pkg::B_IDLE) begin
        count <= count_inc;
      end
      if (clr_prev) begin
        prev_valid <= 1'b0;
      end else if (adv) begin
        prev_status <= rd_data.status;
        prev_time <= rd_data.stamp;
        prev_valid <= 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (res_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind <= load_kind;
      out_byte <= load_byte;
      out_last <= load_last;
    end
  end

  assign res_out.valid = out_valid;
  assign res_out.result_kind = out_kind;
  assign res_out.packet_byte = out_byte;
  assign res_out.last_byte = out_last;

endmodule

FILE: design/ble_midi_packet_builder.sv
// Top level: BLE-MIDI packet builder with message queue and packet streaming.
//
// Usage: msg_in carries one item per handshake. Action enqueue stores a
// timestamped three-byte MIDI message in a ring of QUEUE_DEPTH slots (one
// slot stays free); action emit drains the ring into one BLE-MIDI packet of
// at most PACKET_BYTES bytes, leaving what does not fit queued. res_out
// returns one result per enqueue (accepted or rejected) or per empty emit,
// and one result per packet byte for a packet, last_byte high on the final
// result of each item. Results pass through the command queue and the
// output register, a packet's header byte also through the header state;
// packet bytes follow at one per cycle while res_out.ready stays high.
// Throughput: enqueues run at one item per cycle through the two-entry
// command queue while res_out.ready is high; a non-empty emit holds msg_in
// until the back end loads its last byte into the output register.
// Reset: rst clears both ring indices (queue empty), the command queue and
// the output valid flag; memory contents need no clearing.
// Stall: when res_out.ready is low the output register holds its result,
// the command queue fills and msg_in.ready drops.
`timescale 1ns / 1ps
module ble_midi_packet_builder #(
  parameter int QUEUE_DEPTH = 16,
  parameter int PACKET_BYTES = 20
) (
  input logic        clk,
  input logic        rst,
  bmpb_in_if.sink    msg_in,
  bmpb_out_if.source res_out
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  logic [IDX_W-1:0]       read_index;
  logic [IDX_W-1:0]       wr_addr;
  bmpb_pkg::back_status_t back_stat;
  bmpb_pkg::wr_req_t      wr;
  bmpb_pkg::cmd_t         push_cmd;
  bmpb_pkg::cmd_t         pop_cmd;
  logic                   push;
  logic                   pop;
  logic                   fifo_full;
  logic                   fifo_empty;

  bmpb_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .msg_in    (msg_in),
    .read_index(read_index),
    .back_stat (back_stat),
    .fifo_full (fifo_full),
    .push      (push),
    .push_cmd  (push_cmd),
    .wr        (wr),
    .wr_addr   (wr_addr)
  );

  bmpb_cmd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .pop_cmd (pop_cmd),
    .full    (fifo_full),
    .empty   (fifo_empty)
  );

  bmpb_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PACKET_BYTES(PACKET_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .wr_addr   (wr_addr),
    .cmd_avail (!fifo_empty),
    .cmd       (pop_cmd),
    .pop       (pop),
    .read_index(read_index),
    .back_stat (back_stat),
    .res_out   (res_out)
  );

endmodule

FILE: design/bmpb_checker.sv
// Checker: port-level assertions on the packet builder, bound to the top level.
`timescale 1ns / 1ps
`include "ble_midi_packet_builder_macros.svh"
module bmpb_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] result_kind,
  input logic [7:0] packet_byte,
  input logic       last_byte
);

  logic in_packet;
  logic is_byte;
  logic first_byte;

  assign is_byte = (result_kind == bmpb_pkg::KIND_BYTE);
  assign first_byte = is_byte && !in_packet;

  // Track whether the next byte result continues an open packet.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet <= 1'b0;
    end else if (out_valid && out_ready) begin
      in_packet <= is_byte && !last_byte;
    end
  end

  `BMPB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped in stall")
  `BMPB_ASSERT_NOW(a_status_last, out_valid && !is_byte, last_byte, "status result not last")
  `BMPB_ASSERT_NOW(a_status_zero, out_valid && !is_byte, packet_byte == '0, "status byte set")
  `BMPB_ASSERT_NOW(a_header_mark, out_valid && first_byte, packet_byte[7], "header lacks mark")
  `BMPB_ASSERT_NOW(a_no_mix, out_valid && in_packet, is_byte, "status result inside packet")

endmodule

bind ble_midi_packet_builder bmpb_checker u_bmpb_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (res_out.valid),
  .out_ready  (res_out.ready),
  .result_kind(res_out.result_kind),
  .packet_byte(res_out.packet_byte),
  .last_byte  (res_out.last_byte)
);
